/* rtl/sane_pkg.sv */
`default_nettype none
package sane_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 64;

  localparam int NUM_SUMS = 14;
  localparam int NUM_MAT  = 10;

  localparam logic [2:0] REG_GRAD_THRESH   = 3'd0;
  localparam logic [2:0] REG_CENTER_X      = 3'd1;
  localparam logic [2:0] REG_CENTER_Y      = 3'd2;
  localparam logic [2:0] REG_ROBUST_ENABLE = 3'd3;
  localparam logic [2:0] REG_INV_SIGMA_SQ  = 3'd4;

  localparam logic [2:0] SEL_T4 = 3'd4;

  typedef struct packed {
    logic [15:0] grad_thresh;
    logic [12:0] center_x;
    logic [12:0] center_y;
    logic        robust_enable;
    logic [31:0] inv_sigma_sq;
  } sane_cfg_t;

  typedef struct packed {
    logic upd;
    logic fend;
  } sane_ctl_t;

  // Left operand of each sum: e index, or the scaled difference for the right side.
  function automatic logic [2:0] sane_sel_a(input logic [3:0] k);
    logic [2:0] s;
    case (k)
      4'd0, 4'd1, 4'd3, 4'd6: s = 3'd0;
      4'd2, 4'd4, 4'd7:       s = 3'd1;
      4'd5, 4'd8:             s = 3'd2;
      4'd9:                   s = 3'd3;
      default:                s = SEL_T4;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] sane_sel_b(input logic [3:0] k);
    logic [1:0] s;
    case (k)
      4'd0:                          s = 2'd0;
      4'd1, 4'd2, 4'd11:             s = 2'd1;
      4'd3, 4'd4, 4'd5, 4'd12:       s = 2'd2;
      4'd6, 4'd7, 4'd8, 4'd9, 4'd13: s = 2'd3;
      default:                       s = 2'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/sane_front.sv */
`default_nettype none
module sane_front
  import sane_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int DW = SAMPLE_BITS + 1,
  localparam int CW = ((COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13) + 1,
  localparam int QW = 2 + 3 * DW + 2 * CW
) (
  input  wire sane_cfg_t               cfg,
  input  wire logic [COORD_BITS-1:0]   pixel_x,
  input  wire logic [COORD_BITS-1:0]   pixel_y,
  input  wire logic [SAMPLE_BITS-1:0]  ref_sample,
  input  wire logic [SAMPLE_BITS-1:0]  warp_center,
  input  wire logic [SAMPLE_BITS-1:0]  warp_left,
  input  wire logic [SAMPLE_BITS-1:0]  warp_right,
  input  wire logic [SAMPLE_BITS-1:0]  warp_up,
  input  wire logic [SAMPLE_BITS-1:0]  warp_down,
  input  wire logic [4:0]              invalid_mask,
  input  wire logic                    frame_end,
  output logic                         keep,
  output logic [QW-1:0]                entry
);

  localparam int TW = (DW > 17) ? DW : 17;

  logic signed [DW-1:0] t, dx, dy;
  logic [DW-1:0] mag_dx, mag_dy;
  logic [TW-1:0] th2;
  logic [CW-1:0] xh, yh;
  logic pass;
  sane_ctl_t ctl;

  always_comb begin
    t  = DW'(signed'(warp_center)) - DW'(signed'(ref_sample));
    dx = DW'(signed'(warp_right)) - DW'(signed'(warp_left));
    dy = DW'(signed'(warp_down)) - DW'(signed'(warp_up));
    mag_dx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    mag_dy = dy[DW-1] ? DW'(-dy) : DW'(dy);
    th2 = TW'({cfg.grad_thresh, 1'b0});
    pass = (TW'(mag_dx) >= th2) || (TW'(mag_dy) >= th2);
    xh = {{(CW-COORD_BITS-1){1'b0}}, pixel_x, 1'b0} - {{(CW-13){1'b0}}, cfg.center_x};
    yh = {{(CW-COORD_BITS-1){1'b0}}, pixel_y, 1'b0} - {{(CW-13){1'b0}}, cfg.center_y};
    ctl.upd  = (invalid_mask == 5'd0) && pass;
    ctl.fend = frame_end;
    keep  = ctl.upd || ctl.fend;
    entry = {ctl, t, dx, dy, xh, yh};
  end

endmodule
`default_nettype wire

/* rtl/sane_queue.sv */
`default_nettype none
module sane_queue
  import sane_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  nonempty,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/sane_back.sv */
`default_nettype none
module sane_back
  import sane_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF,
  localparam int DW = SAMPLE_BITS + 1,
  localparam int CW = ((COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13) + 1,
  localparam int QW = 2 + 3 * DW + 2 * CW
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sane_cfg_t         cfg,
  input  wire logic              q_nonempty,
  input  wire logic [QW-1:0]     q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [3:0]             out_sum_index,
  output logic [63:0]            out_sum_value,
  output logic                   out_last_sum
);

  localparam int EW   = DW + CW + 1;
  localparam int T2W  = 2 * (DW - 1);
  localparam int M1   = (EW > T2W) ? EW : T2W;
  localparam int OPW  = ((M1 > 32) ? M1 : 32) + 1;
  localparam int PW   = 2 * OPW;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQ   = 5'd1;
  localparam logic [4:0] S_RS   = 5'd2;
  localparam logic [4:0] S_RD   = 5'd3;
  localparam logic [4:0] S_DIV  = 5'd4;
  localparam logic [4:0] S_W0   = 5'd5;
  localparam logic [4:0] S_W1   = 5'd6;
  localparam logic [4:0] S_W2   = 5'd7;
  localparam logic [4:0] S_W3   = 5'd8;
  localparam logic [4:0] S_E0   = 5'd9;
  localparam logic [4:0] S_E1   = 5'd10;
  localparam logic [4:0] S_E2   = 5'd11;
  localparam logic [4:0] S_E3   = 5'd12;
  localparam logic [4:0] S_E4   = 5'd13;
  localparam logic [4:0] S_MAC  = 5'd14;
  localparam logic [4:0] S_EMIT = 5'd15;

  localparam logic signed [PW-1:0] PMAX = PW'(64'sh7fffffffffffffff);
  localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (ACC_BITS - 1)) - 66'sd1;
  localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;

  logic [4:0]              state_r, state_nxt;
  sane_ctl_t               ctl_r;
  logic signed [DW-1:0]    t_r, dx_r, dy_r;
  logic signed [CW-1:0]    xh_r, yh_r;
  logic signed [EW-1:0]    e_r [4];
  logic signed [EW-1:0]    ea_r;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic [16:0]             w_r;
  logic [48:0]             den_r;
  logic [48:0]             rem_r;
  logic [5:0]              cnt_r;
  logic [3:0]              k_r;
  logic signed [ACC_BITS-1:0] sums_r [NUM_SUMS];
  logic                    out_valid_r;
  logic [3:0]              out_idx_r;
  logic [63:0]             out_val_r;
  logic                    out_last_r;

  sane_ctl_t               q_ctl;
  logic signed [DW-1:0]    q_t, q_dx, q_dy;
  logic signed [CW-1:0]    q_xh, q_yh;
  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [OPW-1:0]   op_sel_a, op_sel_b;
  logic signed [OPW-1:0]   w_op;
  logic signed [PW-1:0]    rnd_sum;
  logic signed [DW-1:0]    rnd_val;
  logic [63:0]             r_sat;
  logic [49:0]             rem_sh;
  logic                    qbit;
  logic [3:0]              k_prev;
  logic signed [63:0]      psat, pterm;
  logic signed [65:0]      acc_sum;
  logic signed [ACC_BITS-1:0] acc_clamped;
  logic                    out_load;
  logic [2:0]              sa;
  logic [1:0]              sb;

  assign {q_ctl, q_t, q_dx, q_dy, q_xh, q_yh} = q_data;
  assign q_pop    = (state_r == S_IDLE) && q_nonempty;
  assign out_load = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_sum_index = out_idx_r;
  assign out_sum_value = out_val_r;
  assign out_last_sum  = out_last_r;

  always_comb begin
    sa = sane_sel_a(k_r);
    sb = sane_sel_b(k_r);
    op_sel_a = (sa == SEL_T4) ? OPW'(t_r) <<< 2 : OPW'(e_r[sa[1:0]]);
    op_sel_b = OPW'(e_r[sb]);
    w_op = OPW'({1'b0, w_r});
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        mul_a = OPW'(t_r);
        mul_b = OPW'(t_r);
      end
      S_RS: begin
        mul_a = OPW'({1'b0, cfg.inv_sigma_sq});
        mul_b = OPW'({1'b0, prod_r[T2W-1:0]});
      end
      S_W0: begin
        mul_a = OPW'(t_r);
        mul_b = w_op;
      end
      S_W1: begin
        mul_a = OPW'(dx_r);
        mul_b = w_op;
      end
      S_W2: begin
        mul_a = OPW'(dy_r);
        mul_b = w_op;
      end
      S_E0: begin
        mul_a = OPW'(dx_r);
        mul_b = OPW'(xh_r);
      end
      S_E1: begin
        mul_a = OPW'(dy_r);
        mul_b = OPW'(yh_r);
      end
      S_E2: begin
        mul_a = OPW'(dx_r);
        mul_b = OPW'(yh_r);
      end
      S_E3: begin
        mul_a = OPW'(dy_r);
        mul_b = OPW'(xh_r);
      end
      S_MAC: begin
        if (k_r < 4'(NUM_SUMS)) begin
          mul_a = op_sel_a;
          mul_b = op_sel_b;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;

    rnd_sum = prod_r + PW'(32768);
    rnd_val = rnd_sum[16 +: DW];

    r_sat = (|prod_r[PW-1:64]) ? '1 : prod_r[63:0];

    qbit   = (cnt_r == 6'd32);
    rem_sh = {rem_r, qbit};

    k_prev = k_r - 4'd1;
    if (prod_r > PMAX) begin
      psat = 64'sh7fffffffffffffff;
    end else if (prod_r < -PMAX) begin
      psat = -64'sh7fffffffffffffff;
    end else begin
      psat = prod_r[63:0];
    end
    pterm = (k_prev >= 4'(NUM_MAT)) ? -psat : psat;
    acc_sum = 66'(sums_r[k_prev]) + 66'(pterm);
    if (acc_sum > ACC_HI) begin
      acc_clamped = ACC_BITS'(ACC_HI);
    end else if (acc_sum < ACC_LO) begin
      acc_clamped = ACC_BITS'(ACC_LO);
    end else begin
      acc_clamped = ACC_BITS'(acc_sum);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_nonempty) begin
          if (q_ctl.upd) begin
            state_nxt = cfg.robust_enable ? S_SQ : S_E0;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SQ:  state_nxt = S_RS;
      S_RS:  state_nxt = S_RD;
      S_RD:  state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == 6'd0) begin
          state_nxt = S_W0;
        end
      end
      S_W0:  state_nxt = S_W1;
      S_W1:  state_nxt = S_W2;
      S_W2:  state_nxt = S_W3;
      S_W3:  state_nxt = S_E0;
      S_E0:  state_nxt = S_E1;
      S_E1:  state_nxt = S_E2;
      S_E2:  state_nxt = S_E3;
      S_E3:  state_nxt = S_E4;
      S_E4:  state_nxt = S_MAC;
      S_MAC: begin
        if (k_r == 4'(NUM_SUMS)) begin
          state_nxt = ctl_r.fend ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_load && k_r == 4'(NUM_SUMS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (state_r)
      S_IDLE: begin
        ctl_r <= q_ctl;
        t_r   <= q_t;
        dx_r  <= q_dx;
        dy_r  <= q_dy;
        xh_r  <= q_xh;
        yh_r  <= q_yh;
      end
      S_RD: begin
        den_r <= {1'b0, r_sat[63:16]} + 49'd65536;
        rem_r <= '0;
        w_r   <= '0;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= 49'(rem_sh - {1'b0, den_r});
          w_r   <= {w_r[15:0], 1'b1};
        end else begin
          rem_r <= rem_sh[48:0];
          w_r   <= {w_r[15:0], 1'b0};
        end
      end
      S_W1: t_r  <= rnd_val;
      S_W2: dx_r <= rnd_val;
      S_W3: dy_r <= rnd_val;
      S_E1: ea_r <= prod_r[EW-1:0];
      S_E2: e_r[0] <= ea_r + prod_r[EW-1:0];
      S_E3: ea_r <= prod_r[EW-1:0];
      S_E4: begin
        e_r[1] <= ea_r - prod_r[EW-1:0];
        e_r[2] <= EW'(dx_r) <<< 1;
        e_r[3] <= EW'(dy_r) <<< 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_val_r   <= '0;
      out_last_r  <= 1'b0;
      for (int i = 0; i < NUM_SUMS; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= (state_r == S_EMIT);
      end
      case (state_r)
        S_IDLE: k_r <= '0;
        S_RD:   cnt_r <= 6'd32;
        S_DIV:  cnt_r <= cnt_r - 6'd1;
        S_E4:   k_r <= '0;
        S_MAC: begin
          if (k_r != 4'd0) begin
            sums_r[k_prev] <= acc_clamped;
          end
          k_r <= (k_r == 4'(NUM_SUMS)) ? 4'd0 : k_r + 4'd1;
        end
        S_EMIT: begin
          if (out_load) begin
            out_idx_r      <= k_r;
            out_val_r      <= 64'(sums_r[k_r]);
            out_last_r     <= (k_r == 4'(NUM_SUMS - 1));
            sums_r[k_r]    <= '0;
            k_r            <= k_r + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/similarity_alignment_normal_equations.sv */
// Gauss-Newton normal equations for similarity image alignment.
// Pixels enter on the in_ word channel (valid/ready); each carries its
// coordinates, the reference sample and five warped samples. The front end
// classifies a pixel in the cycle it is taken and queues it in a two-entry
// queue; pixels that are skipped and do not end the frame are dropped there.
// The back end works on one queued pixel at a time with one shared multiplier:
// a counted pixel goes through the E and MAC states, and with Cauchy weighting
// first through SQ, RS, RD, DIV and W, where a 33-step restoring divider forms
// the weight. On a frame-end pixel the 14 sums leave on the out_ channel, one
// word per cycle while out_ready is high, index 13 marked last, and each sum is
// cleared as it leaves. A stalled receiver holds the word in the output register
// and the back end waits; input is still taken until the queue is full.
// Registers are written over the APB port: grad_thresh at 0x00, center_x at
// 0x04, center_y at 0x08, robust_enable at 0x0C and inv_sigma_sq at 0x10.
// Synchronous reset clears the registers, the queue and all sums.
`default_nettype none
module similarity_alignment_normal_equations
  import sane_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_BITS-1:0]  in_pixel_x,
  input  wire logic [COORD_BITS-1:0]  in_pixel_y,
  input  wire logic [SAMPLE_BITS-1:0] in_ref_sample,
  input  wire logic [SAMPLE_BITS-1:0] in_warp_center,
  input  wire logic [SAMPLE_BITS-1:0] in_warp_left,
  input  wire logic [SAMPLE_BITS-1:0] in_warp_right,
  input  wire logic [SAMPLE_BITS-1:0] in_warp_up,
  input  wire logic [SAMPLE_BITS-1:0] in_warp_down,
  input  wire logic [4:0]             in_invalid_mask,
  input  wire logic                   in_frame_end,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3:0]                  out_sum_index,
  output logic [63:0]                 out_sum_value,
  output logic                        out_last_sum,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [4:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int DW = SAMPLE_BITS + 1;
  localparam int CW = ((COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13) + 1;
  localparam int QW = 2 + 3 * DW + 2 * CW;

  sane_cfg_t       cfg_r;
  logic [2:0]      reg_idx;
  logic            keep, q_full, q_pop, q_nonempty, push;
  logic [QW-1:0]   entry, q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_GRAD_THRESH:   cfg_r.grad_thresh   <= pwdata[15:0];
        REG_CENTER_X:      cfg_r.center_x      <= pwdata[12:0];
        REG_CENTER_Y:      cfg_r.center_y      <= pwdata[12:0];
        REG_ROBUST_ENABLE: cfg_r.robust_enable <= pwdata[0];
        REG_INV_SIGMA_SQ:  cfg_r.inv_sigma_sq  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRAD_THRESH:   prdata = 32'(cfg_r.grad_thresh);
      REG_CENTER_X:      prdata = 32'(cfg_r.center_x);
      REG_CENTER_Y:      prdata = 32'(cfg_r.center_y);
      REG_ROBUST_ENABLE: prdata = 32'(cfg_r.robust_enable);
      REG_INV_SIGMA_SQ:  prdata = cfg_r.inv_sigma_sq;
      default:           prdata = '0;
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && keep;

  sane_front #(
    .COORD_BITS (COORD_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .cfg         (cfg_r),
    .pixel_x     (in_pixel_x),
    .pixel_y     (in_pixel_y),
    .ref_sample  (in_ref_sample),
    .warp_center (in_warp_center),
    .warp_left   (in_warp_left),
    .warp_right  (in_warp_right),
    .warp_up     (in_warp_up),
    .warp_down   (in_warp_down),
    .invalid_mask(in_invalid_mask),
    .frame_end   (in_frame_end),
    .keep        (keep),
    .entry       (entry)
  );

  sane_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(entry),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .pop_data (q_data)
  );

  sane_back #(
    .COORD_BITS (COORD_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_nonempty   (q_nonempty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sum_index(out_sum_index),
    .out_sum_value(out_sum_value),
    .out_last_sum (out_last_sum)
  );

endmodule
`default_nettype wire
